/* rtl/core/mexp_pkg.sv */
// Shared types and constants for the modular exponentiation block.
// Depends on nothing; imported by every module under rtl/core.
`timescale 1ns / 1ps

package mexp_pkg;

    localparam int WIDTH_DEFAULT = 32;
    localparam int FIELD_W       = 32;

    // operand routing for the shared modular multiplier
    typedef enum logic [1:0] {
        OP_RED = 2'd0,   // base * 1 mod m (initial reduction)
        OP_MUL = 2'd1,   // acc * sq mod m
        OP_SQR = 2'd2    // sq * sq mod m
    } opsel_t;

    typedef struct packed {
        logic   load;
        logic   mul_start;
        opsel_t sel;
        logic   wr_acc;
        logic   wr_sq;
        logic   shift_exp;
        logic   emit;
    } mexp_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic mul_busy;
        logic exp_zero;
        logic exp_last;
        logic exp_lsb;
    } mexp_stat_t;

endpackage

/* rtl/core/mexp_mulmod.sv */
// Bit-serial interleaved modular multiplier: one multiplier bit per cycle, MSB first.
// Depends on mexp_pkg. A modulus of zero means wrap at WIDTH bits.
`timescale 1ns / 1ps

module mexp_mulmod
    import mexp_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEFAULT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] x,
    input  logic [WIDTH-1:0] y,
    input  logic [WIDTH-1:0] m,
    output logic             busy,
    output logic             done,
    output logic [WIDTH-1:0] product
);

    localparam int CNT_W = $clog2(WIDTH);
    localparam int T_W   = WIDTH + 2;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [WIDTH-1:0] r_reg, r_next;
    logic [WIDTH-1:0] x_reg, x_next;
    logic [WIDTH-1:0] y_reg, y_next;
    logic [WIDTH-1:0] m_reg, m_next;
    logic             mz_reg, mz_next;

    logic [T_W-1:0] t;
    logic [T_W-1:0] m1_ext;
    logic [T_W-1:0] m2_ext;
    logic [WIDTH-1:0] r_step;

    // r < m and y < m, so 2r + y < 3m: at most one of m or 2m comes off
    always_comb
    begin
        m1_ext = T_W'(m_reg);
        m2_ext = T_W'({m_reg, 1'b0});
        t = T_W'({r_reg, 1'b0}) + (x_reg[WIDTH-1] ? T_W'(y_reg) : '0);
        if (mz_reg)
        begin
            r_step = t[WIDTH-1:0];
        end
        else if (t >= m2_ext)
        begin
            r_step = WIDTH'(t - m2_ext);
        end
        else if (t >= m1_ext)
        begin
            r_step = WIDTH'(t - m1_ext);
        end
        else
        begin
            r_step = t[WIDTH-1:0];
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        r_next    = r_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        m_next    = m_reg;
        mz_next   = mz_reg;
        if (start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(WIDTH - 1);
            r_next    = '0;
            x_next    = x;
            y_next    = y;
            m_next    = m;
            mz_next   = (m == '0);
        end
        else if (busy_reg)
        begin
            r_next = r_step;
            x_next = {x_reg[WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg  <= r_next;
        x_reg  <= x_next;
        y_reg  <= y_next;
        m_reg  <= m_next;
        mz_reg <= mz_next;
    end

    assign busy    = busy_reg;
    assign done    = done_reg;
    assign product = r_reg;

endmodule

/* rtl/core/mexp_dp.sv */
// Datapath: operand registers, exponent shifter, result register and the shared multiplier.
// Depends on mexp_pkg and mexp_mulmod; driven by mexp_ctrl through mexp_cmd_t.
`timescale 1ns / 1ps

module mexp_dp
    import mexp_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  mexp_cmd_t          cmd,
    output mexp_stat_t         stat,
    input  logic [FIELD_W-1:0] base,
    input  logic [FIELD_W-1:0] exponent,
    input  logic [FIELD_W-1:0] modulus,
    output logic               done,
    output logic [FIELD_W-1:0] power_residue
);

    logic [WIDTH-1:0]   acc_reg, acc_next;
    logic [WIDTH-1:0]   sq_reg, sq_next;
    logic [WIDTH-1:0]   exp_reg, exp_next;
    logic [WIDTH-1:0]   m_reg, m_next;
    logic [FIELD_W-1:0] res_reg, res_next;
    logic               done_reg;

    logic [WIDTH-1:0] base_in, exp_in, mod_in;
    logic [WIDTH-1:0] one_red;
    logic [WIDTH-1:0] mul_x, mul_y;
    logic [WIDTH-1:0] product;
    logic             mul_busy, mul_done;

    assign base_in = base[WIDTH-1:0];
    assign exp_in  = exponent[WIDTH-1:0];
    assign mod_in  = modulus[WIDTH-1:0];

    // 1 mod m: zero for a modulus of one, otherwise one
    assign one_red = (m_reg == WIDTH'(1)) ? '0 : WIDTH'(1);

    always_comb
    begin
        case (cmd.sel)
            OP_RED:
            begin
                mul_x = sq_reg;
                mul_y = one_red;
            end
            OP_MUL:
            begin
                mul_x = acc_reg;
                mul_y = sq_reg;
            end
            OP_SQR:
            begin
                mul_x = sq_reg;
                mul_y = sq_reg;
            end
            default:
            begin
                mul_x = sq_reg;
                mul_y = sq_reg;
            end
        endcase
    end

    mexp_mulmod #(
        .WIDTH (WIDTH)
    ) u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.mul_start),
        .x       (mul_x),
        .y       (mul_y),
        .m       (m_reg),
        .busy    (mul_busy),
        .done    (mul_done),
        .product (product)
    );

    always_comb
    begin
        acc_next = acc_reg;
        sq_next  = sq_reg;
        exp_next = exp_reg;
        m_next   = m_reg;
        res_next = res_reg;
        if (cmd.load)
        begin
            sq_next  = base_in;
            exp_next = exp_in;
            m_next   = mod_in;
            // zero exponent answers 1 even for a modulus of one
            if (exp_in == '0 || mod_in != WIDTH'(1))
            begin
                acc_next = WIDTH'(1);
            end
            else
            begin
                acc_next = '0;
            end
        end
        if (cmd.wr_acc)
        begin
            acc_next = product;
        end
        if (cmd.wr_sq)
        begin
            sq_next = product;
        end
        if (cmd.shift_exp)
        begin
            exp_next = {1'b0, exp_reg[WIDTH-1:1]};
        end
        if (cmd.emit)
        begin
            res_next = FIELD_W'(acc_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        sq_reg  <= sq_next;
        exp_reg <= exp_next;
        m_reg   <= m_next;
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit;
        end
    end

    always_comb
    begin
        stat.mul_done = mul_done;
        stat.mul_busy = mul_busy;
        stat.exp_zero = (exp_reg == '0);
        stat.exp_last = (exp_reg[WIDTH-1:1] == '0);
        stat.exp_lsb  = exp_reg[0];
    end

    assign done          = done_reg;
    assign power_residue = res_reg;

endmodule

/* rtl/core/mexp_ctrl.sv */
// Controller: sequences reduction, multiply and square steps over the exponent bits.
// Depends on mexp_pkg; talks to mexp_dp only through mexp_cmd_t and mexp_stat_t.
`timescale 1ns / 1ps

module mexp_ctrl
    import mexp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  mexp_stat_t stat,
    output mexp_cmd_t  cmd
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_RED_GO   = 7'b0000010,
        S_RED_WAIT = 7'b0000100,
        S_CHECK    = 7'b0001000,
        S_MUL_WAIT = 7'b0010000,
        S_SQR_WAIT = 7'b0100000,
        S_DONE     = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next    = state_reg;
        cmd.load      = 1'b0;
        cmd.mul_start = 1'b0;
        cmd.sel       = OP_SQR;
        cmd.wr_acc    = 1'b0;
        cmd.wr_sq     = 1'b0;
        cmd.shift_exp = 1'b0;
        cmd.emit      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_RED_GO;
                end
            end
            S_RED_GO:
            begin
                if (stat.exp_zero)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.mul_start = 1'b1;
                    cmd.sel       = OP_RED;
                    state_next    = S_RED_WAIT;
                end
            end
            S_RED_WAIT:
            begin
                cmd.sel = OP_RED;
                if (stat.mul_done)
                begin
                    cmd.wr_sq  = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.exp_zero)
                begin
                    state_next = S_DONE;
                end
                else if (stat.exp_lsb)
                begin
                    cmd.mul_start = 1'b1;
                    cmd.sel       = OP_MUL;
                    state_next    = S_MUL_WAIT;
                end
                else
                begin
                    cmd.mul_start = 1'b1;
                    cmd.sel       = OP_SQR;
                    state_next    = S_SQR_WAIT;
                end
            end
            S_MUL_WAIT:
            begin
                cmd.sel = OP_MUL;
                if (stat.mul_done)
                begin
                    cmd.wr_acc = 1'b1;
                    if (stat.exp_last)
                    begin
                        // top exponent bit done: the last square is never used
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.mul_start = 1'b1;
                        cmd.sel       = OP_SQR;
                        state_next    = S_SQR_WAIT;
                    end
                end
            end
            S_SQR_WAIT:
            begin
                cmd.sel = OP_SQR;
                if (stat.mul_done)
                begin
                    cmd.wr_sq     = 1'b1;
                    cmd.shift_exp = 1'b1;
                    state_next    = S_CHECK;
                end
            end
            S_DONE:
            begin
                cmd.emit   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

/* rtl/core/modular_exponentiation.sv */
// Modular exponentiation (square-and-multiply): base^exponent mod modulus.
// Usage and timing:
//   Request channel: drive base, exponent and modulus and raise start; the request
//   is taken at a rising edge where start is high and busy is low. busy stays high
//   until the block can take the next request.
//   Result channel: done pulses for one cycle with power_residue valid; the
//   receiver cannot stall, so the result must be captured in that cycle.
//   Only the low WIDTH bits of each input are used. Zero exponent gives 1.
//   All arithmetic runs on one bit-serial modular multiplier, one product at a
//   time. A request with a nonzero exponent needs one reduction of the base,
//   then per exponent bit up to its top set bit one multiply where the bit is
//   set and one square below the top bit (the final square is skipped). The
//   block takes one request at a time. A zero exponent skips the multiplier.
//   The next request may start in the cycle done is high.
//   Reset clears the controller and the done strobe; no request is in flight.
// Depends on mexp_pkg, mexp_ctrl, mexp_dp, mexp_mulmod.
`timescale 1ns / 1ps

module modular_exponentiation
    import mexp_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [FIELD_W-1:0] base,
    input  logic [FIELD_W-1:0] exponent,
    input  logic [FIELD_W-1:0] modulus,
    output logic               done,
    output logic [FIELD_W-1:0] power_residue
);

    mexp_cmd_t  cmd;
    mexp_stat_t stat;

    mexp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    mexp_dp #(
        .WIDTH (WIDTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .base          (base),
        .exponent      (exponent),
        .modulus       (modulus),
        .done          (done),
        .power_residue (power_residue)
    );

    // a taken request holds the block busy on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request taken but block not busy");

    // never launch a product while the multiplier is still working
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul_start |-> !stat.mul_busy)
        else $error("multiplier started while busy");

    // a result strobe only follows a controller emit
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(cmd.emit))
        else $error("result strobe without emit");

    // results are only written back when a product has completed
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_acc || cmd.wr_sq) |-> stat.mul_done)
        else $error("write-back without finished product");

endmodule

/* tb/sv/tb_modular_exponentiation.sv */
// Testbench for modular_exponentiation: random and corner-case requests checked
// against a square-and-multiply predictor built on 64-bit products.
// Depends on mexp_pkg and the modular_exponentiation RTL.
`timescale 1ns / 1ps

module tb_modular_exponentiation
    import mexp_pkg::*;
;

    localparam int OPW         = WIDTH_DEFAULT;
    localparam int N_RANDOM    = 268;
    localparam int PHASE_LEN   = 40;
    localparam int DRAIN_WAIT  = 2400;
    localparam int CYCLE_LIMIT = 3_000_000;

    typedef struct packed {
        logic [FIELD_W-1:0] base;
        logic [FIELD_W-1:0] exponent;
        logic [FIELD_W-1:0] modulus;
    } modexp_req_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic [FIELD_W-1:0] base = '0;
    logic [FIELD_W-1:0] exponent = '0;
    logic [FIELD_W-1:0] modulus = 32'd1;
    logic               busy;
    logic               done;
    logic [FIELD_W-1:0] power_residue;

    modexp_req_t        req_q[$];
    logic [FIELD_W-1:0] residue_q[$];
    logic               req_taken = 1'b0;
    int                 sent_cnt = 0;
    int                 checked_cnt = 0;
    int                 zero_exp_cnt = 0;
    int                 fail_cnt = 0;
    int                 cycle_cnt = 0;

    modular_exponentiation dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .base          (base),
        .exponent      (exponent),
        .modulus       (modulus),
        .done          (done),
        .power_residue (power_residue)
    );

    always #5 clk = ~clk;

    // Square-and-multiply from the LSB; products kept at 64 bits, reduced at once.
    function automatic logic [FIELD_W-1:0] modpow_expected(logic [FIELD_W-1:0] b,
                                                           logic [FIELD_W-1:0] e,
                                                           logic [FIELD_W-1:0] m);
        logic [63:0] mask;
        logic [63:0] bv;
        logic [63:0] ev;
        logic [63:0] mv;
        logic [63:0] acc;
        logic [63:0] sq;
        mask = (64'd1 << OPW) - 64'd1;
        bv = {32'd0, b} & mask;
        ev = {32'd0, e} & mask;
        mv = {32'd0, m} & mask;
        if (ev == 64'd0)
            return FIELD_W'(1);
        acc = (mv == 64'd0) ? 64'd1 : 64'd1 % mv;
        sq = (mv == 64'd0) ? bv : bv % mv;
        for (int k = 0; k < OPW; k++)
        begin
            if (ev[k])
                acc = (mv == 64'd0) ? ((acc * sq) & mask) : (acc * sq) % mv;
            sq = (mv == 64'd0) ? ((sq * sq) & mask) : (sq * sq) % mv;
        end
        return acc[FIELD_W-1:0];
    endfunction

    function automatic int idle_pct_for(int n);
        int phase;
        if (n < 22)
            return 0;
        phase = ((n - 22) / PHASE_LEN) % 3;
        case (phase)
            0: return 0;
            1: return 61;
            default: return 28;
        endcase
    endfunction

    function automatic logic [FIELD_W-1:0] rand_word();
        return $urandom();
    endfunction

    task automatic add_req(logic [FIELD_W-1:0] b, logic [FIELD_W-1:0] e,
                           logic [FIELD_W-1:0] m);
        modexp_req_t r;
        r.base = b;
        r.exponent = e;
        r.modulus = m;
        req_q.insert(req_q.size(), r);
    endtask

    // Driver: hold a request until taken, then present the next one or idle.
    always @(negedge clk)
    begin
        modexp_req_t r;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (start && !req_taken)
        begin
            start <= 1'b1;
        end
        else if (req_q.size() > 0 && $urandom_range(99) >= idle_pct_for(sent_cnt))
        begin
            r = req_q.pop_front();
            start    <= 1'b1;
            base     <= r.base;
            exponent <= r.exponent;
            modulus  <= r.modulus;
            sent_cnt <= sent_cnt + 1;
        end
        else
        begin
            start <= 1'b0;
        end
    end

    // Monitor: check results first, then record the request taken at this edge.
    always @(posedge clk)
    begin
        logic [FIELD_W-1:0] want;
        req_taken <= rst_n && start && !busy;
        if (rst_n && done)
        begin
            if (residue_q.size() == 0)
            begin
                $error("power_residue: unexpected result, actual %0d", power_residue);
                fail_cnt++;
            end
            else
            begin
                want = residue_q.pop_front();
                checked_cnt++;
                if (power_residue !== want)
                begin
                    $error("power_residue: expected %0d, actual %0d", want, power_residue);
                    fail_cnt++;
                end
            end
        end
        if (rst_n && start && !busy)
        begin
            residue_q.insert(residue_q.size(), modpow_expected(base, exponent, modulus));
            if (exponent == '0)
                zero_exp_cnt++;
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_cnt, residue_q.size());
            $display("tb_modular_exponentiation NOT OK");
            $finish;
        end
    end

    initial
    begin
        logic [FIELD_W-1:0] b;
        logic [FIELD_W-1:0] e;
        logic [FIELD_W-1:0] m;

        // zero exponent, including modulus one
        add_req(32'd0, 32'd0, 32'd1);
        add_req(32'd5, 32'd0, 32'd7);
        add_req(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
        // modulus one with a nonzero exponent
        add_req(32'd12345, 32'd7, 32'd1);
        add_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1);
        // zero and unit bases
        add_req(32'd0, 32'd5, 32'd13);
        add_req(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_req(32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // base at, below and above the modulus
        add_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_req(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
        add_req(32'd100, 32'd1, 32'd7);
        add_req(32'd7, 32'd1, 32'hFFFF_FFFF);
        add_req(32'd2, 32'd31, 32'h8000_0000);
        add_req(32'd3, 32'h8000_0000, 32'hFFFF_FFFB);
        add_req(32'd2, 32'd10, 32'd1000);
        add_req(32'hDEAD_BEEF, 32'hFFFF_FFFF, 32'd2);
        add_req(32'h1234_5678, 32'h9ABC_DEF0, 32'hFFFF_FFF1);
        add_req(32'hFFFF_FFFF, 32'd2, 32'h7FFF_FFFF);
        add_req(32'd4, 32'd13, 32'd497);
        add_req(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555);
        add_req(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            case ($urandom_range(5))
                0: m = $urandom_range(255, 1);
                1: m = 32'd1 << $urandom_range(31);
                2: m = 32'hFFFF_FFFF - $urandom_range(15);
                default:
                begin
                    m = rand_word();
                    if (m == '0)
                        m = 32'd1;
                end
            endcase
            case ($urandom_range(7))
                0: e = $urandom_range(15);
                1: e = 32'd1 << $urandom_range(31);
                2: e = 32'hFFFF_FFFF;
                default: e = rand_word();
            endcase
            case ($urandom_range(7))
                0: b = $urandom_range(2);
                1: b = m - 32'd1;
                2: b = m + $urandom_range(3);
                default: b = rand_word();
            endcase
            add_req(b, e, m);
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (req_q.size() > 0 || start)
            @(posedge clk);
        while (residue_q.size() > 0)
            @(posedge clk);
        // watch for stray results after the last one
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("requests sent: %0d (%0d with zero exponent), results checked: %0d",
                 sent_cnt, zero_exp_cnt, checked_cnt);
        $display("sender idling phases of 0, 61 and 28 percent, %0d cycles", cycle_cnt);
        if (fail_cnt == 0)
            $display("tb_modular_exponentiation OK");
        else
            $display("tb_modular_exponentiation NOT OK");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/mexp_pkg.sv
rtl/core/mexp_mulmod.sv
rtl/core/mexp_dp.sv
rtl/core/mexp_ctrl.sv
rtl/core/modular_exponentiation.sv
tb/sv/tb_modular_exponentiation.sv
